// File: rtl/tty_char_grid_writer_unit_defines.svh
// Assertion macros shared by the terminal character grid writer.
`ifndef TTY_CHAR_GRID_WRITER_UNIT_DEFINES_SVH
`define TTY_CHAR_GRID_WRITER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TTYCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define TTYCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ttycg_pkg.sv
// Types and constants of the terminal character grid writer.
package ttycg_pkg;

  // Fixed field widths of the request, result and configuration items.
  localparam int CellW      = 8;
  localparam int ColFieldW  = 6;
  localparam int RowFieldW  = 5;
  localparam int CountW     = 16;
  localparam int CfgDataW   = 7;
  localparam int CfgIdxW    = 2;
  localparam int LastRowW   = 5;

  // Tab stops fall on multiples of this column count.
  localparam int TabStop = 5;

  // Control codes interpreted by a put request, and the space and zero fill values.
  localparam logic [CellW-1:0] ChBel   = 8'h07;
  localparam logic [CellW-1:0] ChBs    = 8'h08;
  localparam logic [CellW-1:0] ChTab   = 8'h09;
  localparam logic [CellW-1:0] ChLf    = 8'h0A;
  localparam logic [CellW-1:0] ChVt    = 8'h0B;
  localparam logic [CellW-1:0] ChFf    = 8'h0C;
  localparam logic [CellW-1:0] ChCr    = 8'h0D;
  localparam logic [CellW-1:0] ChSpace = 8'h20;
  localparam logic [CellW-1:0] ChNul   = 8'h00;

  // Request kinds.
  localparam logic ReqPut  = 1'b0;
  localparam logic ReqRead = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgLineWidth = 2'd0,
    CfgLastRow   = 2'd1
  } cfg_idx_e;

  // One request item.
  typedef struct packed {
    logic                 req_type;
    logic [CellW-1:0]     char_code;
    logic                 end_of_write;
    logic [RowFieldW-1:0] read_row;
    logic [ColFieldW-1:0] read_col;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [ColFieldW-1:0] cursor_col;
    logic [RowFieldW-1:0] cursor_row;
    logic [CellW-1:0]     read_char;
    logic                 write_done;
    logic [CountW-1:0]    written_count;
  } out_t;

  // Status of the cell sweep unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

// File: rtl/tty_char_grid_writer_unit.sv
// Top level of the terminal character grid writer: sequencer, cursor and counters.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    ttycg_pkg::in_t
//   out      output     out_valid/out_stall  ttycg_pkg::out_t
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A read item passes through the read and hand-off states; a put item writes one cell per cycle
// in up to two runs of cells before the hand-off state, or goes straight to it if it writes none.
// All cell writes go through the one sweep unit and the single grid write port.
// After reset a clearing pass writes zero to the whole grid, row by row, and no item is
// accepted meanwhile; configuration is.
// A finished result waits in the output register while the next item is taken.
`include "tty_char_grid_writer_unit_defines.svh"

module tty_char_grid_writer_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ttycg_pkg::in_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ttycg_pkg::out_t                out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttycg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ttycg_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int ColW  = $clog2(MAX_COLS);
  localparam int RowW  = $clog2(MAX_ROWS);
  localparam int EndW  = ColW + 1;
  localparam int AddrW = RowW + ColW;

  typedef enum logic [5:0] {
    S_CLR_GO  = 6'b000001,
    S_CLR_RUN = 6'b000010,
    S_IDLE    = 6'b000100,
    S_READ    = 6'b001000,
    S_SWEEP   = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Cursor, counters and configuration.
  logic [ColW-1:0]                    cur_col_q, cur_col_d;
  logic [RowW-1:0]                    cur_row_q, cur_row_d;
  logic [2:0]                         mod5_q, mod5_d;
  logic [ttycg_pkg::CountW-1:0]       batch_q, batch_d;
  logic [ttycg_pkg::CfgDataW-1:0]     line_width_q, line_width_d;
  logic [ttycg_pkg::LastRowW-1:0]     last_row_q, last_row_d;
  logic [RowW-1:0]                    clr_row_q, clr_row_d;
  logic                               out_valid_q, out_valid_d;

  // Pending second run of cells and result under construction.
  logic                               sec_pend_q, sec_pend_d;
  logic [RowW-1:0]                    sec_row_q, sec_row_d;
  logic [EndW-1:0]                    sec_start_q, sec_start_d;
  logic [EndW-1:0]                    sec_end_q, sec_end_d;
  logic [ttycg_pkg::CellW-1:0]        sec_val_q, sec_val_d;
  logic                               rd_ok_q, rd_ok_d;
  ttycg_pkg::out_t                    res_q, res_d;
  ttycg_pkg::out_t                    out_q, out_d;

  // Put decode.
  logic [31:0]                        lw32, ew32, lr32, el32, row_inc32;
  logic [EndW-1:0]                    eff_w;
  logic [RowW-1:0]                    nrow;
  logic [EndW-1:0]                    col_ext, col_p1, tab_tgt;
  logic [ColW-1:0]                    nxt_col;
  logic [RowW-1:0]                    nxt_row;
  logic [2:0]                         nxt_mod5;
  logic                               f_go;
  logic [RowW-1:0]                    f_row;
  logic [EndW-1:0]                    f_start, f_end;
  logic [ttycg_pkg::CellW-1:0]        f_val;
  logic                               s_pend;
  logic [RowW-1:0]                    s_row;
  logic [EndW-1:0]                    s_start, s_end;
  logic [ttycg_pkg::CellW-1:0]        s_val;
  logic [ttycg_pkg::CountW-1:0]       batch_inc;
  logic [31:0]                        ncol32, nrow32, ccol32, crow32;

  // Read address.
  logic [31:0]                        rr32, rc32;
  logic                               rd_ok;
  logic [AddrW-1:0]                   raddr;
  logic [ttycg_pkg::CellW-1:0]        rdata;

  // Sweep unit command and status.
  logic                               sw_go;
  logic [RowW-1:0]                    sw_row;
  logic [EndW-1:0]                    sw_start, sw_end;
  logic [ttycg_pkg::CellW-1:0]        sw_val;
  ttycg_pkg::sweep_stat_t             sw_stat;
  logic                               ram_we;
  logic [AddrW-1:0]                   ram_waddr;
  logic [ttycg_pkg::CellW-1:0]        ram_wdata;

  logic                               in_acc;
  logic                               out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Effective line width and last row after clamping.
  always_comb begin
    lw32      = 32'(line_width_q);
    lr32      = 32'(last_row_q);
    ew32      = (lw32 == 32'd0) ? 32'd1 :
                ((lw32 > 32'(MAX_COLS)) ? 32'(MAX_COLS) : lw32);
    el32      = (lr32 > 32'(MAX_ROWS - 1)) ? 32'(MAX_ROWS - 1) : lr32;
    eff_w     = ew32[EndW-1:0];
    row_inc32 = 32'(cur_row_q) + 32'd1;
    nrow      = (row_inc32 <= el32) ? row_inc32[RowW-1:0] : '0;
    col_ext   = {1'b0, cur_col_q};
    col_p1    = col_ext + 1'b1;
    tab_tgt   = col_ext + (EndW'(ttycg_pkg::TabStop) - EndW'(mod5_q));
  end

  // Interpret one put byte: new cursor and up to two runs of cell writes.
  always_comb begin
    nxt_col  = cur_col_q;
    nxt_row  = cur_row_q;
    nxt_mod5 = mod5_q;
    f_go     = 1'b0;
    f_row    = cur_row_q;
    f_start  = col_ext;
    f_end    = col_p1;
    f_val    = ttycg_pkg::ChNul;
    s_pend   = 1'b0;
    s_row    = nrow;
    s_start  = '0;
    s_end    = eff_w;
    s_val    = ttycg_pkg::ChNul;
    unique case (in_data_i.char_code) inside
      ttycg_pkg::ChBel: begin
      end
      ttycg_pkg::ChBs: begin
        if (cur_col_q != '0) begin
          nxt_col  = cur_col_q - 1'b1;
          nxt_mod5 = (mod5_q == 3'd0) ? 3'(ttycg_pkg::TabStop - 1) : mod5_q - 3'd1;
        end
        f_go    = 1'b1;
        f_start = {1'b0, nxt_col};
        f_end   = {1'b0, nxt_col} + 1'b1;
      end
      ttycg_pkg::ChTab: begin
        if (tab_tgt < eff_w) begin
          f_go     = 1'b1;
          f_end    = tab_tgt;
          f_val    = ttycg_pkg::ChSpace;
          nxt_col  = tab_tgt[ColW-1:0];
          nxt_mod5 = 3'd0;
        end else begin
          nxt_col  = '0;
          nxt_mod5 = 3'd0;
          nxt_row  = nrow;
          f_go     = 1'b1;
          f_row    = nrow;
          f_start  = '0;
          f_end    = eff_w;
        end
      end
      ttycg_pkg::ChLf: begin
        nxt_col  = '0;
        nxt_mod5 = 3'd0;
        nxt_row  = nrow;
        f_go     = 1'b1;
        f_row    = nrow;
        f_start  = '0;
        f_end    = eff_w;
      end
      ttycg_pkg::ChFf, ttycg_pkg::ChVt: begin
        nxt_row = nrow;
        f_go    = 1'b1;
        f_row   = nrow;
        f_start = '0;
        f_end   = eff_w;
        s_pend  = 1'b1;
        s_end   = col_ext;
        s_val   = ttycg_pkg::ChSpace;
      end
      ttycg_pkg::ChCr: begin
        nxt_col  = '0;
        nxt_mod5 = 3'd0;
      end
      default: begin
        // Printable byte: store it, then wrap and wipe the new row if the line is full.
        f_go  = 1'b1;
        f_val = in_data_i.char_code;
        if (col_p1 >= eff_w) begin
          nxt_col  = '0;
          nxt_mod5 = 3'd0;
          nxt_row  = nrow;
          s_pend   = 1'b1;
        end else begin
          nxt_col  = col_p1[ColW-1:0];
          nxt_mod5 = (mod5_q == 3'(ttycg_pkg::TabStop - 1)) ? 3'd0 : mod5_q + 3'd1;
        end
      end
    endcase
  end

  // Read address and range check.
  always_comb begin
    rr32  = 32'(in_data_i.read_row);
    rc32  = 32'(in_data_i.read_col);
    rd_ok = (rr32 < 32'(MAX_ROWS)) && (rc32 < 32'(MAX_COLS));
    raddr = {rr32[RowW-1:0], rc32[ColW-1:0]};
  end

  assign batch_inc = (batch_q == '1) ? batch_q : batch_q + 1'b1;

  always_comb begin
    ncol32 = 32'(nxt_col);
    nrow32 = 32'(nxt_row);
    ccol32 = 32'(cur_col_q);
    crow32 = 32'(cur_row_q);
  end

  // Sequencer: clearing pass, request decode, cell runs and result hand-off.
  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    mod5_d      = mod5_q;
    batch_d     = batch_q;
    clr_row_d   = clr_row_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sec_pend_d  = sec_pend_q;
    sec_row_d   = sec_row_q;
    sec_start_d = sec_start_q;
    sec_end_d   = sec_end_q;
    sec_val_d   = sec_val_q;
    rd_ok_d     = rd_ok_q;
    res_d       = res_q;
    sw_go       = 1'b0;
    sw_row      = f_row;
    sw_start    = f_start;
    sw_end      = f_end;
    sw_val      = f_val;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR_GO: begin
        sw_go    = 1'b1;
        sw_row   = clr_row_q;
        sw_start = '0;
        sw_end   = EndW'(2 ** ColW);
        sw_val   = ttycg_pkg::ChNul;
        state_d  = S_CLR_RUN;
      end
      S_CLR_RUN: begin
        sw_row   = clr_row_q + 1'b1;
        sw_start = '0;
        sw_end   = EndW'(2 ** ColW);
        sw_val   = ttycg_pkg::ChNul;
        if (sw_stat.done) begin
          if (clr_row_q == '1) begin
            state_d = S_IDLE;
          end else begin
            clr_row_d = clr_row_q + 1'b1;
            sw_go     = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type == ttycg_pkg::ReqRead) begin
            rd_ok_d                 = rd_ok;
            res_d.cursor_col        = ccol32[ttycg_pkg::ColFieldW-1:0];
            res_d.cursor_row        = crow32[ttycg_pkg::RowFieldW-1:0];
            res_d.read_char         = ttycg_pkg::ChNul;
            res_d.write_done        = 1'b0;
            res_d.written_count     = '0;
            state_d                 = S_READ;
          end else begin
            cur_col_d        = nxt_col;
            cur_row_d        = nxt_row;
            mod5_d           = nxt_mod5;
            sec_pend_d       = s_pend;
            sec_row_d        = s_row;
            sec_start_d      = s_start;
            sec_end_d        = s_end;
            sec_val_d        = s_val;
            res_d.cursor_col = ncol32[ttycg_pkg::ColFieldW-1:0];
            res_d.cursor_row = nrow32[ttycg_pkg::RowFieldW-1:0];
            res_d.read_char  = ttycg_pkg::ChNul;
            if (in_data_i.end_of_write) begin
              res_d.write_done    = 1'b1;
              res_d.written_count = batch_inc;
              batch_d             = '0;
            end else begin
              res_d.write_done    = 1'b0;
              res_d.written_count = '0;
              batch_d             = batch_inc;
            end
            if (f_go) begin
              sw_go   = 1'b1;
              state_d = S_SWEEP;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_READ: begin
        res_d.read_char = rd_ok_q ? rdata : ttycg_pkg::ChNul;
        state_d         = S_DONE;
      end
      S_SWEEP: begin
        sw_row   = sec_row_q;
        sw_start = sec_start_q;
        sw_end   = sec_end_q;
        sw_val   = sec_val_q;
        if (sw_stat.done) begin
          if (sec_pend_q) begin
            sw_go      = 1'b1;
            sec_pend_d = 1'b0;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration register writes.
  always_comb begin
    line_width_d = line_width_q;
    last_row_d   = last_row_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ttycg_pkg::CfgLineWidth: line_width_d = cfg_data_i;
        ttycg_pkg::CfgLastRow:   last_row_d   = cfg_data_i[ttycg_pkg::LastRowW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR_GO;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      mod5_q       <= 3'd0;
      batch_q      <= '0;
      line_width_q <= ttycg_pkg::CfgDataW'(64);
      last_row_q   <= ttycg_pkg::LastRowW'(31);
      clr_row_q    <= '0;
      out_valid_q  <= 1'b0;
      sec_pend_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      mod5_q       <= mod5_d;
      batch_q      <= batch_d;
      line_width_q <= line_width_d;
      last_row_q   <= last_row_d;
      clr_row_q    <= clr_row_d;
      out_valid_q  <= out_valid_d;
      sec_pend_q   <= sec_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_row_q   <= sec_row_d;
    sec_start_q <= sec_start_d;
    sec_end_q   <= sec_end_d;
    sec_val_q   <= sec_val_d;
    rd_ok_q     <= rd_ok_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  // Shared cell sweep unit drives the grid write port.
  ttycg_sweep #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (sw_go),
    .row_i   (sw_row),
    .start_i (sw_start),
    .end_i   (sw_end),
    .value_i (sw_val),
    .we_o    (ram_we),
    .waddr_o (ram_waddr),
    .wdata_o (ram_wdata),
    .stat_o  (sw_stat)
  );

  ttycg_grid_ram #(
    .AddrW (AddrW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // The sweep unit never runs while the block waits for a new item.
  `TTYCG_ASSERT(a_sweep_not_idle, !(sw_stat.busy && (state_q == S_IDLE)),
                "cell sweep active while idle")
  // The cursor row stays inside the grid.
  `TTYCG_ASSERT(a_row_in_grid, 32'(cur_row_q) < 32'(MAX_ROWS), "cursor row outside grid")
  // A new result only appears out of the hand-off state.
  `TTYCG_ASSERT(a_out_from_done, !$rose(out_valid_o) || $past(state_q == S_DONE),
                "result raised outside hand-off")
  // After an item is taken the block is busy in the next cycle.
  `TTYCG_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "item taken back to back")

endmodule

// File: rtl/ttycg_grid_ram.sv
// Character grid memory with one write port and one registered read port.
module ttycg_grid_ram #(
  parameter int AddrW = 11
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [ttycg_pkg::CellW-1:0] wdata_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [ttycg_pkg::CellW-1:0] rdata_o
);

  logic [ttycg_pkg::CellW-1:0] mem [2**AddrW];
  logic [ttycg_pkg::CellW-1:0] rdata_q;

  // Write and read in the same clocked block; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ttycg_sweep.sv
// Cell sweep unit: writes one value to a run of columns of one row, one cell per cycle.
module ttycg_sweep #(
  parameter int ColW = 6,
  parameter int RowW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [RowW-1:0]             row_i,
  input  logic [ColW:0]               start_i,
  input  logic [ColW:0]               end_i,
  input  logic [ttycg_pkg::CellW-1:0] value_i,
  output logic                        we_o,
  output logic [RowW+ColW-1:0]        waddr_o,
  output logic [ttycg_pkg::CellW-1:0] wdata_o,
  output ttycg_pkg::sweep_stat_t      stat_o
);

  logic                        active_q, active_d;
  logic [ColW:0]               col_q, col_d;
  logic [ColW:0]               end_q, end_d;
  logic [RowW-1:0]             row_q, row_d;
  logic [ttycg_pkg::CellW-1:0] val_q, val_d;
  logic                        at_end;

  // The run is over once the column reaches the exclusive end.
  assign at_end  = (col_q >= end_q);
  assign we_o    = active_q && !at_end;
  assign waddr_o = {row_q, col_q[ColW-1:0]};
  assign wdata_o = val_q;

  assign stat_o.busy = active_q;
  assign stat_o.done = active_q && at_end;

  // A new command takes priority over finishing the current one.
  always_comb begin
    active_d = active_q;
    col_d    = col_q;
    end_d    = end_q;
    row_d    = row_q;
    val_d    = val_q;
    if (go_i) begin
      active_d = 1'b1;
      col_d    = start_i;
      end_d    = end_i;
      row_d    = row_i;
      val_d    = value_i;
    end else if (active_q) begin
      if (at_end) begin
        active_d = 1'b0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    end_q <= end_d;
    row_q <= row_d;
    val_q <= val_d;
  end

endmodule

// File: verif/tty_char_grid_writer_unit_test.sv
// Self-checking testbench of the terminal character grid writer unit.
`timescale 1ns / 1ps

module tty_char_grid_writer_unit_test;

  localparam int GridCols = 64;
  localparam int GridRows = 32;
  localparam int DrainCycles = 200;
  localparam int MaxReports = 10;

  // Directed stimulus row: either a register write or an item.
  typedef struct {
    bit                             is_cfg;
    ttycg_pkg::cfg_idx_e            idx;
    logic [ttycg_pkg::CfgDataW-1:0] val;
    ttycg_pkg::in_t                 req;
    bit                             typed;
    ttycg_pkg::out_t                want;
  } dir_row_t;

  // Random phase: idling of both sides, register setting and item count.
  typedef struct {
    int                             send_pct;
    int                             recv_pct;
    logic [ttycg_pkg::CfgDataW-1:0] width;
    logic [ttycg_pkg::LastRowW-1:0] last;
    int                             items;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  ttycg_pkg::in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  ttycg_pkg::out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [ttycg_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [ttycg_pkg::CfgDataW-1:0] cfg_data_i;

  // Shadow copy of the terminal state.
  logic [ttycg_pkg::CellW-1:0]    screen [GridRows][GridCols];
  int unsigned                    col;
  int unsigned                    row;
  logic [ttycg_pkg::CountW-1:0]   put_count;
  logic [ttycg_pkg::CfgDataW-1:0] width_reg;
  logic [ttycg_pkg::LastRowW-1:0] last_row_reg;

  ttycg_pkg::out_t awaited_status [$];
  int              mismatch_count = 0;
  int              sender_idle_pct = 0;
  int              recv_idle_pct = 0;
  dir_row_t        plan [$];
  phase_t          phases [5];

  tty_char_grid_writer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Columns in use, with zero read as one and wide values clipped to the grid.
  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > GridCols) return GridCols;
    return width_reg;
  endfunction

  function automatic void set_cell(int unsigned r, int unsigned c,
                                   logic [ttycg_pkg::CellW-1:0] v);
    if (r < GridRows && c < GridCols) screen[r][c] = v;
  endfunction

  // Step to the next row, wrapping after the last row, and wipe it.
  function automatic void advance_row();
    int unsigned w;
    w = used_width();
    row = (row + 1 <= last_row_reg) ? row + 1 : 0;
    for (int unsigned c = 0; c < w; c++) set_cell(row, c, ttycg_pkg::ChNul);
  endfunction

  // Interpret one byte at the cursor.
  function automatic void apply_byte(logic [ttycg_pkg::CellW-1:0] ch);
    int unsigned w;
    int unsigned off;
    w = used_width();
    case (ch)
      ttycg_pkg::ChBel: begin
      end
      ttycg_pkg::ChBs: begin
        if (col > 0) col--;
        set_cell(row, col, ttycg_pkg::ChNul);
      end
      ttycg_pkg::ChTab: begin
        off = ttycg_pkg::TabStop - (col % ttycg_pkg::TabStop);
        if (col + off < w) begin
          for (int unsigned i = 0; i < off; i++) set_cell(row, col + i, ttycg_pkg::ChSpace);
          col += off;
        end else begin
          col = 0;
          advance_row();
        end
      end
      ttycg_pkg::ChLf: begin
        col = 0;
        advance_row();
      end
      ttycg_pkg::ChFf, ttycg_pkg::ChVt: begin
        advance_row();
        for (int unsigned i = 0; i < col && i < GridCols; i++)
          set_cell(row, i, ttycg_pkg::ChSpace);
      end
      ttycg_pkg::ChCr: begin
        col = 0;
      end
      default: begin
        set_cell(row, col, ch);
        col++;
        if (col >= w) begin
          advance_row();
          col = 0;
        end
      end
    endcase
  endfunction

  // Expected status after one request; updates the shadow state.
  function automatic ttycg_pkg::out_t terminal_step(ttycg_pkg::in_t req);
    ttycg_pkg::out_t res;
    res = '0;
    if (req.req_type == ttycg_pkg::ReqRead) begin
      res.read_char = screen[req.read_row][req.read_col];
    end else begin
      apply_byte(req.char_code);
      if (put_count != {ttycg_pkg::CountW{1'b1}}) put_count++;
      if (req.end_of_write) begin
        res.write_done = 1'b1;
        res.written_count = put_count;
        put_count = '0;
      end
    end
    res.cursor_col = col[ttycg_pkg::ColFieldW-1:0];
    res.cursor_row = row[ttycg_pkg::RowFieldW-1:0];
    return res;
  endfunction

  function automatic ttycg_pkg::in_t put_item(logic [ttycg_pkg::CellW-1:0] ch, logic eow);
    ttycg_pkg::in_t req;
    req.req_type = ttycg_pkg::ReqPut;
    req.char_code = ch;
    req.end_of_write = eow;
    req.read_row = ttycg_pkg::RowFieldW'($urandom);
    req.read_col = ttycg_pkg::ColFieldW'($urandom);
    return req;
  endfunction

  function automatic ttycg_pkg::in_t read_item(int r, int c, logic [ttycg_pkg::CellW-1:0] ch,
                                               logic eow);
    ttycg_pkg::in_t req;
    req.req_type = ttycg_pkg::ReqRead;
    req.char_code = ch;
    req.end_of_write = eow;
    req.read_row = ttycg_pkg::RowFieldW'(r);
    req.read_col = ttycg_pkg::ColFieldW'(c);
    return req;
  endfunction

  function automatic void plan_item(ttycg_pkg::in_t req);
    dir_row_t d;
    d = '{is_cfg: 1'b0, idx: ttycg_pkg::CfgLineWidth, val: '0, req: req, typed: 1'b0,
          want: '0};
    plan.push_back(d);
  endfunction

  function automatic void plan_reg(ttycg_pkg::cfg_idx_e idx,
                                   logic [ttycg_pkg::CfgDataW-1:0] val);
    dir_row_t d;
    d = '{is_cfg: 1'b1, idx: idx, val: val, req: '0, typed: 1'b0, want: '0};
    plan.push_back(d);
  endfunction

  // Random request: mostly text with control codes, some reads, half of them on the cursor row.
  function automatic ttycg_pkg::in_t random_request();
    int pick;
    logic [ttycg_pkg::CellW-1:0] ch;
    logic [ttycg_pkg::CellW-1:0] ctl [7];
    ctl = '{ttycg_pkg::ChBel, ttycg_pkg::ChBs, ttycg_pkg::ChTab, ttycg_pkg::ChLf,
            ttycg_pkg::ChVt, ttycg_pkg::ChFf, ttycg_pkg::ChCr};
    pick = $urandom_range(99);
    if (pick < 25) begin
      return read_item(($urandom_range(1) != 0) ? int'(row) : $urandom_range(GridRows - 1),
                       $urandom_range(GridCols - 1), ttycg_pkg::CellW'($urandom),
                       ($urandom_range(7) == 0));
    end
    pick = $urandom_range(99);
    if (pick < 60) ch = ttycg_pkg::CellW'($urandom_range(8'h7E, 8'h20));
    else if (pick < 88) ch = ctl[$urandom_range(6)];
    else ch = ttycg_pkg::CellW'($urandom);
    return put_item(ch, ($urandom_range(7) == 0));
  endfunction

  // Present one item and record its expected status once it is taken.
  task automatic push_request(ttycg_pkg::in_t req, bit typed, ttycg_pkg::out_t want);
    ttycg_pkg::out_t got;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    got = terminal_step(req);
    awaited_status.push_back(typed ? want : got);
  endtask

  // Hold the input back until every expected status has come.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(ttycg_pkg::cfg_idx_e idx, logic [ttycg_pkg::CfgDataW-1:0] val);
    wait_quiet();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ttycg_pkg::CfgLineWidth: width_reg = val;
      ttycg_pkg::CfgLastRow:   last_row_reg = val[ttycg_pkg::LastRowW-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stall, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every taken status with the oldest expectation.
  always @(posedge clk_i) begin
    ttycg_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected status item: col %0d row %0d char %02h done %0b count %0d",
                   out_data_o.cursor_col, out_data_o.cursor_row, out_data_o.read_char,
                   out_data_o.write_done, out_data_o.written_count);
      end else begin
        want = awaited_status.pop_front();
        if (out_data_o.cursor_col !== want.cursor_col ||
            out_data_o.cursor_row !== want.cursor_row ||
            out_data_o.read_char !== want.read_char ||
            out_data_o.write_done !== want.write_done ||
            out_data_o.written_count !== want.written_count) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: expected col %0d row %0d char %02h done %0b count %0d, %s",
                     want.cursor_col, want.cursor_row, want.read_char, want.write_done,
                     want.written_count,
                     $sformatf("got col %0d row %0d char %02h done %0b count %0d",
                               out_data_o.cursor_col, out_data_o.cursor_row,
                               out_data_o.read_char, out_data_o.write_done,
                               out_data_o.written_count));
        end
      end
    end
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #8000000;
    $display("tty_char_grid_writer_unit_test: FAIL");
    $finish;
  end

  initial begin
    dir_row_t       d;
    ttycg_pkg::in_t req;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ttycg_pkg::CfgLineWidth;
    cfg_data_i = '0;
    for (int r = 0; r < GridRows; r++)
      for (int c = 0; c < GridCols; c++) screen[r][c] = ttycg_pkg::ChNul;
    col = 0;
    row = 0;
    put_count = '0;
    width_reg = 7'd64;
    last_row_reg = 5'd31;

    // Directed part. A read right after reset sees a clear grid and a home cursor,
    // with its end-of-write flag ignored.
    d = '{is_cfg: 1'b0, idx: ttycg_pkg::CfgLineWidth, val: '0,
          req: read_item(31, 63, 8'hFF, 1'b1), typed: 1'b1, want: '0};
    plan.push_back(d);
    d.req = put_item(8'h41, 1'b1);
    d.want = '{cursor_col: 6'd1, cursor_row: 5'd0, read_char: 8'h00, write_done: 1'b1,
               written_count: 16'd1};
    plan.push_back(d);
    plan_item(put_item(ttycg_pkg::ChBel, 1'b0));
    plan_item(put_item(ttycg_pkg::ChBs, 1'b0));
    // Backspace at column zero stays there.
    plan_item(put_item(ttycg_pkg::ChBs, 1'b0));
    plan_item(put_item(ttycg_pkg::ChTab, 1'b0));
    plan_item(put_item(8'hFF, 1'b0));
    // A zero byte is stored like any printable one.
    plan_item(put_item(ttycg_pkg::ChNul, 1'b0));
    plan_item(put_item(ttycg_pkg::ChFf, 1'b0));
    plan_item(put_item(ttycg_pkg::ChVt, 1'b0));
    plan_item(put_item(ttycg_pkg::ChCr, 1'b0));
    plan_item(put_item(ttycg_pkg::ChLf, 1'b1));
    plan_item(read_item(0, 0, 8'h00, 1'b0));
    plan_item(read_item(1, 5, 8'h00, 1'b0));
    plan_item(put_item(ttycg_pkg::ChTab, 1'b0));
    plan_item(put_item(ttycg_pkg::ChTab, 1'b0));
    // Zero width acts as one; the cursor is left beyond the new width.
    plan_reg(ttycg_pkg::CfgLineWidth, 7'd0);
    plan_item(put_item(8'h7A, 1'b0));
    plan_item(put_item(ttycg_pkg::ChTab, 1'b0));
    // Width above the grid is clipped; a last row of zero keeps the cursor on row zero.
    plan_reg(ttycg_pkg::CfgLineWidth, 7'd127);
    plan_reg(ttycg_pkg::CfgLastRow, 5'd0);
    plan_item(put_item(ttycg_pkg::ChLf, 1'b0));
    plan_item(read_item(2, 10, 8'h55, 1'b0));
    plan_reg(ttycg_pkg::CfgLastRow, 5'd31);
    plan_item(put_item(8'h80, 1'b1));

    phases[0] = '{send_pct: 21, recv_pct: 83, width: 7'd20,  last: 5'd3,  items: 250};
    phases[1] = '{send_pct: 21, recv_pct: 83, width: 7'd64,  last: 5'd31, items: 100};
    phases[2] = '{send_pct: 83, recv_pct: 21, width: 7'd1,   last: 5'd0,  items: 150};
    phases[3] = '{send_pct: 83, recv_pct: 21, width: 7'd127, last: 5'd7,  items: 150};
    phases[4] = '{send_pct: 0,  recv_pct: 0,  width: 7'd9,   last: 5'd2,  items: 350};

    // Reset once, released at a falling edge.
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = phases[0].send_pct;
    recv_idle_pct = phases[0].recv_pct;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else push_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // Random phases, each with its own register setting and idling.
    foreach (phases[p]) begin
      wait_quiet();
      sender_idle_pct = phases[p].send_pct;
      recv_idle_pct = phases[p].recv_pct;
      write_reg(ttycg_pkg::CfgLineWidth, phases[p].width);
      write_reg(ttycg_pkg::CfgLastRow, phases[p].last);
      for (int n = 0; n < phases[p].items; n++) begin
        if (n == phases[p].items / 2) wait_quiet();
        req = random_request();
        push_request(req, 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_status.size() == 0) begin
      $display("tty_char_grid_writer_unit_test: PASS");
    end else begin
      $display("tty_char_grid_writer_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ttycg_pkg.sv
rtl/ttycg_grid_ram.sv
rtl/ttycg_sweep.sv
rtl/tty_char_grid_writer_unit.sv
verif/tty_char_grid_writer_unit_test.sv
